FILE: sv/tkbt_pkg.sv
package tkbt_pkg;

    // Q0.16 fixed point.
    localparam int unsigned Q16_W = 16;
    localparam logic [Q16_W:0] Q16_ONE = 17'h1_0000;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    typedef logic [APB_ADDR_W-3:0] reg_idx_t;

    localparam reg_idx_t REG_PRESS_THRESHOLD = 1'd0;
    localparam reg_idx_t REG_BASELINE_WEIGHT = 1'd1;

    localparam logic [Q16_W-1:0] PRESS_THRESHOLD_RST = 16'd58982;
    localparam logic [Q16_W-1:0] BASELINE_WEIGHT_RST = 16'd64880;

endpackage

FILE: sv/tkbt_update.sv
module tkbt_update #(
    parameter int unsigned COUNT_BITS = 14
) (
    input  logic [COUNT_BITS-1:0]        sample,
    input  logic [COUNT_BITS-1:0]        base_cur,
    input  logic [COUNT_BITS-1:0]        filt_cur,
    input  logic [tkbt_pkg::Q16_W-1:0]   threshold,
    input  logic [tkbt_pkg::Q16_W-1:0]   weight,
    output logic                         pressed,
    output logic [COUNT_BITS-1:0]        filt_new,
    output logic [COUNT_BITS-1:0]        base_new
);

    localparam int unsigned PW = COUNT_BITS + tkbt_pkg::Q16_W;
    localparam int unsigned AW = COUNT_BITS + tkbt_pkg::Q16_W + 2;

    logic                         seed;
    logic [COUNT_BITS-1:0]        base_s;
    logic [COUNT_BITS-1:0]        filt_s;
    logic [COUNT_BITS:0]          sum;
    logic [PW-1:0]                lhs;
    logic [PW-1:0]                rhs;
    logic [tkbt_pkg::Q16_W:0]     new_weight;
    logic [AW-1:0]                acc;

    // An unseeded channel takes the count as both baseline and filtered level.
    assign seed   = (base_cur == '0);
    assign base_s = seed ? sample : base_cur;
    assign filt_s = seed ? sample : filt_cur;

    assign sum      = {1'b0, filt_s} + {1'b0, sample};
    assign filt_new = sum[COUNT_BITS:1];

    assign lhs     = {filt_new, {tkbt_pkg::Q16_W{1'b0}}};
    assign rhs     = PW'(threshold) * PW'(base_s);
    assign pressed = (lhs < rhs);

    assign new_weight = tkbt_pkg::Q16_ONE - {1'b0, weight};
    assign acc        = AW'(base_s) * AW'(weight) + AW'(filt_new) * AW'(new_weight);

    assign base_new = pressed ? base_s
                              : acc[tkbt_pkg::Q16_W +: COUNT_BITS];

endmodule

FILE: sv/touch_key_baseline_toggle.sv
// Capacitive touch key scanner. Each accepted word carries one acquisition
// count for the channel named by an internal round-robin pointer, starting at
// channel 0 after reset. The block keeps a filtered level and a baseline per
// channel, judges a press when filtered/baseline falls below press_threshold
// (Q0.16), toggles the channel's status bit once per press and lets the
// baseline follow the filtered level while the pad is released, with
// baseline_weight (Q0.16) as the weight of the old baseline. Each word gives
// exactly one result word. A word passes an input register and is worked
// combinationally into the result register, so the block takes a word every
// cycle; the throughput is set only by the result channel's ready. Registers
// sit at byte address 0 (press_threshold) and 4 (baseline_weight) and should be
// written only while no word is in flight.
module touch_key_baseline_toggle #(
    parameter int unsigned CHANNELS   = 5,
    parameter int unsigned COUNT_BITS = 14
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tkbt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tkbt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tkbt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [COUNT_BITS-1:0]               s_sample_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] m_channel_done,
    output logic                                m_is_pressed,
    output logic [CHANNELS-1:0]                 m_toggle_bits,
    output logic [COUNT_BITS-1:0]               m_filtered_level,
    output logic [COUNT_BITS-1:0]               m_baseline_level
);

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [tkbt_pkg::Q16_W-1:0]   threshold_reg;
    logic [tkbt_pkg::Q16_W-1:0]   weight_reg;
    tkbt_pkg::reg_idx_t           reg_idx;

    logic                         in_valid_reg;
    logic [COUNT_BITS-1:0]        in_sample_reg;
    logic                         m_valid_reg;
    logic [CH_W-1:0]              ch_out_reg;
    logic                         pressed_out_reg;
    logic [CHANNELS-1:0]          toggle_out_reg;
    logic [COUNT_BITS-1:0]        filt_out_reg;
    logic [COUNT_BITS-1:0]        base_out_reg;

    logic [COUNT_BITS-1:0]        base_reg [CHANNELS];
    logic [COUNT_BITS-1:0]        filt_reg [CHANNELS];
    logic [CHANNELS-1:0]          ack_reg;
    logic [CHANNELS-1:0]          status_reg;
    logic [CH_W-1:0]              ptr_reg;

    logic [CHANNELS-1:0]          ack_next;
    logic [CHANNELS-1:0]          status_next;
    logic [CH_W-1:0]              ptr_next;
    logic [CH_W-1:0]              ch;
    logic                         advance;
    logic                         fire;
    logic                         pressed;
    logic [COUNT_BITS-1:0]        filt_new;
    logic [COUNT_BITS-1:0]        base_new;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[tkbt_pkg::APB_ADDR_W-1:2];

    always_comb begin
        case (reg_idx)
            tkbt_pkg::REG_PRESS_THRESHOLD: prdata = tkbt_pkg::APB_DATA_W'(threshold_reg);
            tkbt_pkg::REG_BASELINE_WEIGHT: prdata = tkbt_pkg::APB_DATA_W'(weight_reg);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= tkbt_pkg::PRESS_THRESHOLD_RST;
            weight_reg    <= tkbt_pkg::BASELINE_WEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                tkbt_pkg::REG_PRESS_THRESHOLD: threshold_reg <= pwdata[tkbt_pkg::Q16_W-1:0];
                tkbt_pkg::REG_BASELINE_WEIGHT: weight_reg    <= pwdata[tkbt_pkg::Q16_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: input register feeds the combinational update into the result register.
    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample_count;
        end
    end

    // Channel selection and per-channel update.
    assign ch = ({1'b0, ptr_reg} < (CH_W+1)'(CHANNELS)) ? ptr_reg : '0;
    assign ptr_next = (ch == CH_W'(CHANNELS - 1)) ? '0 : ch + 1'b1;

    tkbt_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .sample    (in_sample_reg),
        .base_cur  (base_reg[ch]),
        .filt_cur  (filt_reg[ch]),
        .threshold (threshold_reg),
        .weight    (weight_reg),
        .pressed   (pressed),
        .filt_new  (filt_new),
        .base_new  (base_new)
    );

    always_comb begin
        ack_next    = ack_reg;
        status_next = status_reg;
        if (pressed) begin
            if (!ack_reg[ch]) begin
                status_next[ch] = !status_reg[ch];
                ack_next[ch]    = 1'b1;
            end
        end else begin
            ack_next[ch] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                base_reg[i] <= '0;
                filt_reg[i] <= '0;
            end
            ack_reg    <= '0;
            status_reg <= '0;
            ptr_reg    <= '0;
        end else if (fire) begin
            base_reg[ch] <= base_new;
            filt_reg[ch] <= filt_new;
            ack_reg      <= ack_next;
            status_reg   <= status_next;
            ptr_reg      <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            ch_out_reg      <= ch;
            pressed_out_reg <= pressed;
            toggle_out_reg  <= status_next;
            filt_out_reg    <= filt_new;
            base_out_reg    <= base_new;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_channel_done   = ch_out_reg;
    assign m_is_pressed     = pressed_out_reg;
    assign m_toggle_bits    = toggle_out_reg;
    assign m_filtered_level = filt_out_reg;
    assign m_baseline_level = base_out_reg;

endmodule

FILE: sv/tkbt_check.sv
module tkbt_check #(
    parameter int unsigned CHANNELS   = 5,
    parameter int unsigned COUNT_BITS = 14
) (
    input logic                                           aclk,
    input logic                                           aresetn,
    input logic                                           m_valid,
    input logic                                           m_ready,
    input logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] m_channel_done,
    input logic                                           m_is_pressed,
    input logic [CHANNELS-1:0]                            m_toggle_bits,
    input logic [COUNT_BITS-1:0]                          m_filtered_level,
    input logic [COUNT_BITS-1:0]                          m_baseline_level
);

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // No result word may appear straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel_done)
            && $stable(m_is_pressed) && $stable(m_toggle_bits)
            && $stable(m_filtered_level) && $stable(m_baseline_level))
        else $error("stalled result word changed");

    // The channel index stays in range.
    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_channel_done} < (CH_W+1)'(CHANNELS)))
        else $error("channel index out of range");

    // Consecutive result words visit the channels in round-robin order.
    a_chan_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |->
            (m_channel_done == (($past(m_channel_done) == CH_W'(CHANNELS - 1))
                                ? '0 : $past(m_channel_done) + 1'b1)))
        else $error("channel order broken");

    // Only one toggle bit may change between consecutive result words.
    a_one_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |->
            $onehot0(m_toggle_bits ^ $past(m_toggle_bits)))
        else $error("more than one toggle bit changed");

endmodule

bind touch_key_baseline_toggle tkbt_check #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
) u_tkbt_check (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_channel_done   (m_channel_done),
    .m_is_pressed     (m_is_pressed),
    .m_toggle_bits    (m_toggle_bits),
    .m_filtered_level (m_filtered_level),
    .m_baseline_level (m_baseline_level)
);
